>>> rtl/afb_pkg.sv
// Shared types, constants and frame assembly for the ARP frame builder.
// No dependencies; used by every module under rtl/.
`default_nettype none

package afb_pkg;

  localparam int unsigned HW_ADDR_BYTES    = 6;
  localparam int unsigned PROTO_ADDR_BYTES = 4;
  localparam int unsigned FRAME_BYTES      = 14 + 8 + 2 * (HW_ADDR_BYTES + PROTO_ADDR_BYTES);
  localparam int unsigned CNT_W            = $clog2(FRAME_BYTES);
  localparam int unsigned MAC_W            = 8 * HW_ADDR_BYTES;
  localparam int unsigned IP_W             = 8 * PROTO_ADDR_BYTES;
  localparam int unsigned CFG_DATA_W       = MAC_W;
  localparam int unsigned CFG_IDX_W        = 1;
  localparam int unsigned QUEUE_DEPTH      = 2;

  localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
  localparam logic [15:0] HTYPE_ETH     = 16'h0001;
  localparam logic [15:0] PTYPE_IPV4    = 16'h0800;
  localparam logic [7:0]  HLEN          = 8'(HW_ADDR_BYTES);
  localparam logic [7:0]  PLEN          = 8'(PROTO_ADDR_BYTES);
  localparam logic [MAC_W-1:0] MAC_BCAST = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOCAL_MAC = 1'b0,
    CFG_LOCAL_IP  = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    CMD_REQUEST = 1'b0,
    CMD_REPLY   = 1'b1
  } cmd_e;

  typedef struct packed {
    logic             command;
    logic [IP_W-1:0]  target_ip;
    logic [MAC_W-1:0] target_mac;
    logic             broadcast;
  } req_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frm_t;

  typedef struct packed {
    logic [MAC_W-1:0] local_mac;
    logic [IP_W-1:0]  local_ip;
  } cfg_t;

  typedef struct packed {
    logic [MAC_W-1:0] dest_mac;
    logic [MAC_W-1:0] tgt_mac;
    logic [IP_W-1:0]  tgt_ip;
    logic             is_reply;
  } job_t;

  typedef logic [FRAME_BYTES-1:0][7:0] frame_vec_t;

  // Byte 0 of the frame sits in the top lane.
  function automatic frame_vec_t build_frame(job_t job, cfg_t cfg);
    logic [15:0] opcode;
    opcode = {14'b0, job.is_reply, ~job.is_reply};
    return {job.dest_mac, cfg.local_mac, ETHERTYPE_ARP, HTYPE_ETH, PTYPE_IPV4,
            HLEN, PLEN, opcode, cfg.local_mac, cfg.local_ip, job.tgt_mac, job.tgt_ip};
  endfunction

endpackage

`default_nettype wire

>>> rtl/afb_front.sv
// Request classifier: resolves destination MAC, target MAC field and opcode.
// Depends on afb_pkg.
`default_nettype none

module afb_front (
  input  afb_pkg::req_t req_i,
  output afb_pkg::job_t job_o
);

  always_comb begin
    job_o.is_reply = (req_i.command == afb_pkg::CMD_REPLY);
    job_o.dest_mac = req_i.broadcast ? afb_pkg::MAC_BCAST : req_i.target_mac;
    job_o.tgt_mac  = job_o.is_reply ? req_i.target_mac : '0;
    job_o.tgt_ip   = req_i.target_ip;
  end

endmodule

`default_nettype wire

>>> rtl/afb_queue.sv
// Small register FIFO of classified jobs between front and back.
// Depends on afb_pkg.
`default_nettype none

module afb_queue #(
  parameter int unsigned DEPTH = afb_pkg::QUEUE_DEPTH
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           push_i,
  input  afb_pkg::job_t push_data_i,
  output logic          full_o,
  input  wire           pop_i,
  output afb_pkg::job_t pop_data_o,
  output logic          empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  afb_pkg::job_t    mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == CNT_W'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/afb_back.sv
// Frame serializer: walks a job byte by byte into a registered output stage.
// Depends on afb_pkg.
`default_nettype none

module afb_back (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  afb_pkg::cfg_t cfg_i,
  input  afb_pkg::job_t job_i,
  input  wire           job_avail_i,
  output logic          job_pop_o,
  output afb_pkg::frm_t frm_o,
  output logic          frm_valid_o,
  input  wire           frm_ready_i
);

  localparam logic [afb_pkg::CNT_W-1:0] LAST_IDX = afb_pkg::CNT_W'(afb_pkg::FRAME_BYTES - 1);

  afb_pkg::job_t              job_q;
  logic                       busy_q;
  logic [afb_pkg::CNT_W-1:0]  cnt_q, lane;
  afb_pkg::frm_t              out_q;
  logic                       out_valid_q;
  afb_pkg::frame_vec_t        frame;
  logic                       adv, at_last;

  assign frame     = afb_pkg::build_frame(job_q, cfg_i);
  assign lane      = LAST_IDX - cnt_q;
  assign at_last   = (cnt_q == LAST_IDX);
  assign adv       = busy_q && (!out_valid_q || frm_ready_i);
  assign job_pop_o = job_avail_i && (!busy_q || (adv && at_last));

  assign frm_o       = out_q;
  assign frm_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (frm_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (job_pop_o) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (adv) begin
        if (at_last) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end
    if (adv) begin
      out_q.frame_byte <= frame[lane];
      out_q.last_byte  <= at_last;
    end
  end

endmodule

`default_nettype wire

>>> rtl/arp_frame_builder.sv
// Top level of the ARP frame builder: config registers, front, queue, back.
// Depends on afb_pkg, afb_front, afb_queue, afb_back.
//
//   channel | signals                          | dir | payload
//   --------+----------------------------------+-----+-----------------------------
//   req     | req_valid_i / req_ready_o        | in  | afb_pkg::req_t
//   frm     | frm_valid_o / frm_ready_i        | out | afb_pkg::frm_t, one byte
//   cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i | in  | local_mac (0), local_ip (1)
//
// Each transaction on req yields 42 frm transactions, one per cycle when frm is
// not stalled; frames follow each other with no gap while jobs wait in the queue.
// Requests are written into the job queue and are taken while a frame is still
// going out. Reset clears the queue, the byte counter in the back end, the
// output valid flag and both config registers to zero.
`default_nettype none

module arp_frame_builder #(
  parameter int unsigned QUEUE_DEPTH = afb_pkg::QUEUE_DEPTH
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire [afb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire [afb_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  afb_pkg::req_t                    req_i,
  input  wire                              req_valid_i,
  output logic                             req_ready_o,
  output afb_pkg::frm_t                    frm_o,
  output logic                             frm_valid_o,
  input  wire                              frm_ready_i
);

  afb_pkg::cfg_t cfg_q;
  afb_pkg::job_t front_job, queue_job;
  logic          q_full, q_empty, q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        afb_pkg::CFG_LOCAL_MAC: cfg_q.local_mac <= cfg_wdata_i[afb_pkg::MAC_W-1:0];
        afb_pkg::CFG_LOCAL_IP:  cfg_q.local_ip  <= cfg_wdata_i[afb_pkg::IP_W-1:0];
        default: ;
      endcase
    end
  end

  assign req_ready_o = !q_full;

  afb_front u_front (
    .req_i (req_i),
    .job_o (front_job)
  );

  afb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (req_valid_i),
    .push_data_i (front_job),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (queue_job),
    .empty_o     (q_empty)
  );

  afb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_i       (queue_job),
    .job_avail_i (!q_empty),
    .job_pop_o   (q_pop),
    .frm_o       (frm_o),
    .frm_valid_o (frm_valid_o),
    .frm_ready_i (frm_ready_i)
  );

endmodule

`default_nettype wire

>>> tb/arp_frame_builder_test.sv
// Self-checking testbench for arp_frame_builder: ARP send requests in, frame bytes out.
// Depends on afb_pkg and the RTL under rtl/; a scoreboard class predicts each byte.
`timescale 1ns / 1ps

module arp_frame_builder_test;

  localparam int unsigned CYCLE_LIMIT = 400000;

  class frame_scoreboard;
    localparam int unsigned ARP_FRAME_LEN = 42;
    localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;
    localparam logic [15:0] ARP_HW_ETH    = 16'h0001;
    localparam logic [15:0] ARP_PROTO_IP  = 16'h0800;
    localparam logic [15:0] OPCODE_REQ    = 16'h0001;
    localparam logic [15:0] OPCODE_REPLY  = 16'h0002;

    afb_pkg::frm_t expected_bytes[$];
    logic [47:0]   local_mac;
    logic [31:0]   local_ip;
    logic [7:0]    frame_buf[ARP_FRAME_LEN];
    int            fill;
    int            errors;
    int            checked;

    function new();
      local_mac = '0;
      local_ip  = '0;
      errors    = 0;
      checked   = 0;
    endfunction

    function void set_config(logic [47:0] mac, logic [31:0] ip);
      local_mac = mac;
      local_ip  = ip;
    endfunction

    function void put_be(logic [63:0] value, int nbytes);
      for (int i = nbytes - 1; i >= 0; i--) begin
        frame_buf[fill] = value[8*i +: 8];
        fill++;
      end
    endfunction

    function void note_request(afb_pkg::req_t r);
      afb_pkg::frm_t b;
      logic          reply;
      reply = (r.command == afb_pkg::CMD_REPLY);
      fill = 0;
      put_be(r.broadcast ? 64'hffff_ffff_ffff : {16'h0, r.target_mac},
             afb_pkg::HW_ADDR_BYTES);
      put_be({16'h0, local_mac}, afb_pkg::HW_ADDR_BYTES);
      put_be({48'h0, ETH_TYPE_ARP}, 2);
      put_be({48'h0, ARP_HW_ETH}, 2);
      put_be({48'h0, ARP_PROTO_IP}, 2);
      put_be(64'(afb_pkg::HW_ADDR_BYTES), 1);
      put_be(64'd4, 1);
      put_be({48'h0, reply ? OPCODE_REPLY : OPCODE_REQ}, 2);
      put_be({16'h0, local_mac}, afb_pkg::HW_ADDR_BYTES);
      put_be({32'h0, local_ip}, 4);
      put_be(reply ? {16'h0, r.target_mac} : 64'h0, afb_pkg::HW_ADDR_BYTES);
      put_be({32'h0, r.target_ip}, 4);
      for (int k = 0; k < fill; k++) begin
        b.frame_byte = frame_buf[k];
        b.last_byte  = (k == fill - 1);
        expected_bytes.push_back(b);
      end
    endfunction

    function void check_byte(afb_pkg::frm_t got);
      afb_pkg::frm_t want;
      checked++;
      if (expected_bytes.size() == 0) begin
        $error("unexpected frame byte %02h (last_byte %0b)", got.frame_byte, got.last_byte);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got.frame_byte !== want.frame_byte) begin
        $error("frame_byte: expected %02h, actual %02h", want.frame_byte, got.frame_byte);
        errors++;
      end
      if (got.last_byte !== want.last_byte) begin
        $error("last_byte: expected %0b, actual %0b", want.last_byte, got.last_byte);
        errors++;
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [afb_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [afb_pkg::CFG_DATA_W-1:0] cfg_wdata_i;
  afb_pkg::req_t                  req_i;
  logic                           req_valid_i;
  logic                           req_ready_o;
  afb_pkg::frm_t                  frm_o;
  logic                           frm_valid_o;
  logic                           frm_ready_i;

  frame_scoreboard sb;
  int unsigned     cycles;
  int              requests_sent;
  int              cfg_writes;
  int              settings_used;
  int              stall_mode;

  arp_frame_builder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .frm_o       (frm_o),
    .frm_valid_o (frm_valid_o),
    .frm_ready_i (frm_ready_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes outstanding", cycles, sb.pending());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // frame receiver: check accepted transactions, stall on a changing pattern
  always @(posedge clk_i) begin
    if (rst_ni && frm_valid_o && frm_ready_i) sb.check_byte(frm_o);
    if (cycles % 180 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: frm_ready_i <= 1'b1;
      1: frm_ready_i <= ($urandom_range(0, 3) != 0);
      2: frm_ready_i <= (cycles % 7 != 3);
      default: frm_ready_i <= 1'($urandom_range(0, 1));
    endcase
  end

  task automatic send_request(afb_pkg::req_t r);
    req_i       <= r;
    req_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!req_ready_o) @(posedge clk_i);
    sb.note_request(r);
    requests_sent++;
  endtask

  task automatic send_fields(logic cmd, logic [31:0] ip, logic [47:0] mac, logic bc);
    afb_pkg::req_t r;
    r.command    = cmd;
    r.target_ip  = ip;
    r.target_mac = mac;
    r.broadcast  = bc;
    send_request(r);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      req_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // sender waits until every frame byte has left the block
  task automatic drain();
    req_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_config(logic [47:0] mac, logic [31:0] ip, logic [15:0] junk);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= afb_pkg::CFG_LOCAL_MAC;
    cfg_wdata_i <= mac;
    @(posedge clk_i);
    cfg_idx_i   <= afb_pkg::CFG_LOCAL_IP;
    cfg_wdata_i <= {junk, ip};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_config(mac, ip);
    cfg_writes += 2;
    settings_used++;
  endtask

  function automatic afb_pkg::req_t random_request();
    afb_pkg::req_t r;
    r.command    = 1'($urandom_range(0, 1));
    r.broadcast  = 1'($urandom_range(0, 1));
    r.target_ip  = $urandom;
    r.target_mac = {16'($urandom), 32'($urandom)};
    case ($urandom_range(0, 15))
      0: r.target_ip  = '0;
      1: r.target_ip  = '1;
      2: r.target_mac = '0;
      3: r.target_mac = '1;
      default: ;
    endcase
    return r;
  endfunction

  task automatic run_random(int count);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && left > 0) begin
        send_request(random_request());
        burst--;
        left--;
      end
      case ($urandom_range(0, 3))
        0: ;
        1: idle_gap($urandom_range(1, 4));
        2: idle_gap($urandom_range(5, 30));
        default: idle_gap($urandom_range(30, 90));
      endcase
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= afb_pkg::CFG_LOCAL_MAC;
    cfg_wdata_i   <= '0;
    req_i         <= '0;
    req_valid_i   <= 1'b0;
    frm_ready_i   <= 1'b0;
    cycles        = 0;
    requests_sent = 0;
    cfg_writes    = 0;
    settings_used = 1;
    stall_mode    = 0;
    sb            = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config, every command/broadcast pair
    send_fields(afb_pkg::CMD_REQUEST, 32'h0000_0000, 48'h0000_0000_0000, 1'b0);
    send_fields(afb_pkg::CMD_REQUEST, 32'hffff_ffff, 48'hffff_ffff_ffff, 1'b1);
    send_fields(afb_pkg::CMD_REPLY,   32'h0000_0000, 48'hffff_ffff_ffff, 1'b0);
    send_fields(afb_pkg::CMD_REPLY,   32'hffff_ffff, 48'h0000_0000_0000, 1'b1);
    drain();

    write_config(48'hffff_ffff_ffff, 32'hffff_ffff, 16'h0000);
    send_fields(afb_pkg::CMD_REQUEST, 32'hc0a8_0101, 48'h0011_2233_4455, 1'b1);
    send_fields(afb_pkg::CMD_REQUEST, 32'h0a00_0001, 48'h0011_2233_4455, 1'b0);
    send_fields(afb_pkg::CMD_REPLY,   32'hc0a8_0101, 48'h0011_2233_4455, 1'b0);
    send_fields(afb_pkg::CMD_REPLY,   32'h0a00_0001, 48'h0011_2233_4455, 1'b1);
    send_fields(afb_pkg::CMD_REPLY,   32'haaaa_aaaa, 48'h5555_5555_5555, 1'b0);
    send_fields(afb_pkg::CMD_REPLY,   32'h5555_5555, 48'haaaa_aaaa_aaaa, 1'b0);
    drain();

    // upper data bits on the IP write must be dropped
    write_config(48'h0000_0000_0001, 32'h0000_0001, 16'hffff);
    send_fields(afb_pkg::CMD_REQUEST, 32'h8000_0000, 48'h8000_0000_0000, 1'b0);
    send_fields(afb_pkg::CMD_REPLY,   32'h0000_0001, 48'h0000_0000_0001, 1'b0);
    send_fields(afb_pkg::CMD_REPLY,   32'hffff_ffff, 48'hffff_ffff_ffff, 1'b0);
    send_fields(afb_pkg::CMD_REQUEST, 32'h1234_5678, 48'h9abc_def0_1234, 1'b1);
    drain();

    write_config(48'haaaa_aaaa_aaaa, 32'h5555_5555, 16'ha5a5);
    send_fields(afb_pkg::CMD_REPLY,   32'h7f00_0001, 48'h0200_0000_0001, 1'b0);
    send_fields(afb_pkg::CMD_REQUEST, 32'h7f00_0001, 48'h0200_0000_0001, 1'b0);
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: write_config(48'h0, 32'h0, 16'($urandom));
        1: write_config(48'hffff_ffff_ffff, 32'hffff_ffff, 16'($urandom));
        default: write_config({16'($urandom), 32'($urandom)}, $urandom, 16'($urandom));
      endcase
      run_random(49);
      drain();
    end

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("Sent %0d ARP requests (request/reply, broadcast/unicast, extreme addresses),",
             requests_sent);
    $display("checked %0d frame bytes under %0d register settings (%0d writes).",
             sb.checked, settings_used, cfg_writes);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
